@@ design/lfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lfd_pkg;

  localparam int unsigned LED_COUNT_W = 11;
  localparam int unsigned PIX_ADDR_W  = 12;
  localparam int unsigned LINE_IDX_W  = 8;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [LED_COUNT_W-1:0] MaxLeds  = 11'd1024;
  localparam logic [LINE_IDX_W-1:0]  LineLast = 8'd255;

  localparam logic [7:0] ChkSeed     = 8'h55;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperC  = 8'h43;
  localparam logic [7:0] CharLowA    = 8'h61;
  localparam logic [7:0] CharLowD    = 8'h64;
  localparam logic [7:0] CharLowM    = 8'h6d;
  localparam logic [7:0] CharNewline = 8'h0a;

  typedef enum logic {
    REG_LED_COUNT      = 1'b0,
    REG_TARGET_PRESENT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_ADA_D    = 4'd1,
    ST_ADA_A    = 4'd2,
    ST_ADA_HI   = 4'd3,
    ST_ADA_LO   = 4'd4,
    ST_ADA_CHK  = 4'd5,
    ST_ADA_DATA = 4'd6,
    ST_CMD_M    = 4'd7,
    ST_CMD_D    = 4'd8,
    ST_CMD_LINE = 4'd9
  } parse_state_t;

  typedef struct packed {
    logic [LED_COUNT_W-1:0] led_count;
    logic                   target_present;
  } cfg_t;

  typedef struct packed {
    logic                  pixel_write;
    logic [PIX_ADDR_W-1:0] pixel_addr;
    logic [7:0]            pixel_byte;
    logic                  frame_done;
    logic                  header_error;
    logic                  cmd_write;
    logic [LINE_IDX_W-1:0] cmd_index;
    logic [7:0]            cmd_byte;
    logic                  cmd_line_done;
    logic [LINE_IDX_W-1:0] cmd_length;
  } result_t;

endpackage

`default_nettype wire

@@ design/lfd_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfd_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lfd_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [lfd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [lfd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output lfd_pkg::cfg_t                        cfg
);

  lfd_pkg::cfg_t     cfg_r;
  lfd_pkg::cfg_t     cfg_nxt;
  lfd_pkg::reg_idx_t reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lfd_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        lfd_pkg::REG_LED_COUNT:
          cfg_nxt.led_count = pwdata[lfd_pkg::LED_COUNT_W-1:0];
        lfd_pkg::REG_TARGET_PRESENT:
          cfg_nxt.target_present = pwdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lfd_pkg::REG_LED_COUNT:
        prdata = {{(lfd_pkg::APB_DATA_W-lfd_pkg::LED_COUNT_W){1'b0}}, cfg_r.led_count};
      lfd_pkg::REG_TARGET_PRESENT:
        prdata = {{(lfd_pkg::APB_DATA_W-1){1'b0}}, cfg_r.target_present};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count      <= '0;
      cfg_r.target_present <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/led_frame_and_command_deframer_core.sv @@
// led frame and command deframer
// input channel: one received serial byte per request (in_rx_byte) under
//   in_valid / in_ready.
// result channel: one result per input byte under out_valid / out_ready:
//   pixel store strobe with byte address and value, frame done, header
//   error, command byte store with index, and line done with length.
// config: apb-style port, led_count at 0x0, target_present at 0x4; write
//   only while the parser is idle. led_count is sampled at each good header.
// the result of a byte is registered and on the outputs in the cycle after
//   the byte is taken. throughput: one byte per cycle while the output is
//   not stalled, set by the single state register update per byte.
// stall: the output register holds its result while out_ready is low; a new
//   byte is still taken in the cycle that the held result leaves.
// reset (synchronous, rst_n low): parser to idle, counters cleared, no
//   result pending, led_count 0, target_present 1.
`timescale 1ns / 1ps
`default_nettype none

module led_frame_and_command_deframer_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_pixel_write,
  output logic      [lfd_pkg::PIX_ADDR_W-1:0]  out_pixel_addr,
  output logic      [7:0]                      out_pixel_byte,
  output logic                                 out_frame_done,
  output logic                                 out_header_error,
  output logic                                 out_cmd_write,
  output logic      [lfd_pkg::LINE_IDX_W-1:0]  out_cmd_index,
  output logic      [7:0]                      out_cmd_byte,
  output logic                                 out_cmd_line_done,
  output logic      [lfd_pkg::LINE_IDX_W-1:0]  out_cmd_length,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lfd_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [lfd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [lfd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  lfd_pkg::cfg_t         cfg;
  lfd_pkg::parse_state_t state_r, state_nxt;
  logic [7:0]                      hdr_hi_r, hdr_hi_nxt;
  logic [7:0]                      hdr_lo_r, hdr_lo_nxt;
  logic [lfd_pkg::PIX_ADDR_W-1:0]  pay_cnt_r, pay_cnt_nxt;
  logic [lfd_pkg::PIX_ADDR_W-1:0]  pay_total_r, pay_total_nxt;
  logic [lfd_pkg::LINE_IDX_W-1:0]  line_idx_r, line_idx_nxt;
  lfd_pkg::result_t      res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  accept;
  logic [lfd_pkg::LED_COUNT_W-1:0] led_lim;
  logic [lfd_pkg::PIX_ADDR_W-1:0]  cnt_inc;

  lfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign led_lim = (cfg.led_count > lfd_pkg::MaxLeds) ? lfd_pkg::MaxLeds : cfg.led_count;

  always_comb begin
    state_nxt     = state_r;
    hdr_hi_nxt    = hdr_hi_r;
    hdr_lo_nxt    = hdr_lo_r;
    pay_cnt_nxt   = pay_cnt_r;
    pay_total_nxt = pay_total_r;
    line_idx_nxt  = line_idx_r;
    res_nxt       = '0;
    cnt_inc       = pay_cnt_r;
    unique case (state_r)
      lfd_pkg::ST_IDLE: begin
        if (in_rx_byte == lfd_pkg::CharUpperA) begin
          state_nxt = lfd_pkg::ST_ADA_D;
        end else if (in_rx_byte == lfd_pkg::CharUpperC) begin
          state_nxt = lfd_pkg::ST_CMD_M;
        end
      end
      lfd_pkg::ST_ADA_D: begin
        if (in_rx_byte == lfd_pkg::CharLowD) begin
          state_nxt = lfd_pkg::ST_ADA_A;
        end else begin
          state_nxt = lfd_pkg::ST_IDLE;
          res_nxt.header_error = 1'b1;
        end
      end
      lfd_pkg::ST_ADA_A: begin
        if (in_rx_byte == lfd_pkg::CharLowA) begin
          state_nxt = lfd_pkg::ST_ADA_HI;
        end else begin
          state_nxt = lfd_pkg::ST_IDLE;
          res_nxt.header_error = 1'b1;
        end
      end
      lfd_pkg::ST_ADA_HI: begin
        hdr_hi_nxt = in_rx_byte;
        state_nxt  = lfd_pkg::ST_ADA_LO;
      end
      lfd_pkg::ST_ADA_LO: begin
        hdr_lo_nxt = in_rx_byte;
        state_nxt  = lfd_pkg::ST_ADA_CHK;
      end
      lfd_pkg::ST_ADA_CHK: begin
        if ((hdr_hi_r ^ hdr_lo_r ^ lfd_pkg::ChkSeed) == in_rx_byte) begin
          pay_cnt_nxt   = '0;
          pay_total_nxt = {led_lim, 1'b0} + {1'b0, led_lim};
          state_nxt     = lfd_pkg::ST_ADA_DATA;
        end else begin
          state_nxt = lfd_pkg::ST_IDLE;
          res_nxt.header_error = 1'b1;
        end
      end
      lfd_pkg::ST_ADA_DATA: begin
        if (!cfg.target_present) begin
          state_nxt = lfd_pkg::ST_IDLE;
          res_nxt.header_error = 1'b1;
        end else begin
          if (pay_cnt_r < pay_total_r) begin
            res_nxt.pixel_write = 1'b1;
            res_nxt.pixel_addr  = pay_cnt_r;
            res_nxt.pixel_byte  = in_rx_byte;
            cnt_inc             = pay_cnt_r + 1'b1;
          end
          pay_cnt_nxt = cnt_inc;
          if (cnt_inc >= pay_total_r) begin
            state_nxt = lfd_pkg::ST_IDLE;
            res_nxt.frame_done = 1'b1;
          end
        end
      end
      lfd_pkg::ST_CMD_M: begin
        if (in_rx_byte == lfd_pkg::CharLowM) begin
          state_nxt = lfd_pkg::ST_CMD_D;
        end else begin
          state_nxt = lfd_pkg::ST_IDLE;
          res_nxt.header_error = 1'b1;
        end
      end
      lfd_pkg::ST_CMD_D: begin
        if (in_rx_byte == lfd_pkg::CharLowD) begin
          state_nxt    = lfd_pkg::ST_CMD_LINE;
          line_idx_nxt = '0;
        end else begin
          state_nxt = lfd_pkg::ST_IDLE;
          res_nxt.header_error = 1'b1;
        end
      end
      lfd_pkg::ST_CMD_LINE: begin
        if (in_rx_byte == lfd_pkg::CharNewline) begin
          res_nxt.cmd_line_done = 1'b1;
          res_nxt.cmd_length    = line_idx_r;
          state_nxt             = lfd_pkg::ST_IDLE;
        end else if (line_idx_r < lfd_pkg::LineLast) begin
          res_nxt.cmd_write = 1'b1;
          res_nxt.cmd_index = line_idx_r;
          res_nxt.cmd_byte  = in_rx_byte;
          line_idx_nxt      = line_idx_r + 1'b1;
        end
      end
      default: state_nxt = lfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfd_pkg::ST_IDLE;
      hdr_hi_r    <= '0;
      hdr_lo_r    <= '0;
      pay_cnt_r   <= '0;
      pay_total_r <= '0;
      line_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        state_r     <= state_nxt;
        hdr_hi_r    <= hdr_hi_nxt;
        hdr_lo_r    <= hdr_lo_nxt;
        pay_cnt_r   <= pay_cnt_nxt;
        pay_total_r <= pay_total_nxt;
        line_idx_r  <= line_idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_write   = res_r.pixel_write;
  assign out_pixel_addr    = res_r.pixel_addr;
  assign out_pixel_byte    = res_r.pixel_byte;
  assign out_frame_done    = res_r.frame_done;
  assign out_header_error  = res_r.header_error;
  assign out_cmd_write     = res_r.cmd_write;
  assign out_cmd_index     = res_r.cmd_index;
  assign out_cmd_byte      = res_r.cmd_byte;
  assign out_cmd_line_done = res_r.cmd_line_done;
  assign out_cmd_length    = res_r.cmd_length;

endmodule

`default_nettype wire

@@ design/lfd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            out_pixel_write,
  input wire logic [lfd_pkg::PIX_ADDR_W-1:0]  out_pixel_addr,
  input wire logic [7:0]                      out_pixel_byte,
  input wire logic                            out_frame_done,
  input wire logic                            out_header_error,
  input wire logic                            out_cmd_write,
  input wire logic                            out_cmd_line_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_addr) && $stable(out_pixel_byte))
    else $error("result changed while stalled");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte gave no result");

  a_one_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_pixel_write && out_cmd_write)
                  && !(out_frame_done && out_header_error)
                  && !(out_pixel_write && out_cmd_line_done))
    else $error("conflicting result flags");

  a_idle_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_write |-> out_pixel_addr == '0 && out_pixel_byte == '0)
    else $error("pixel fields set without a store");

endmodule

bind led_frame_and_command_deframer_core lfd_checker u_lfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_pixel_write   (out_pixel_write),
  .out_pixel_addr    (out_pixel_addr),
  .out_pixel_byte    (out_pixel_byte),
  .out_frame_done    (out_frame_done),
  .out_header_error  (out_header_error),
  .out_cmd_write     (out_cmd_write),
  .out_cmd_line_done (out_cmd_line_done)
);

`default_nettype wire

@@ sim/led_frame_and_command_deframer_core_tb.sv @@
`timescale 1ns / 1ps

module led_frame_and_command_deframer_core_tb;
  import lfd_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_pixel_write;
  logic [PIX_ADDR_W-1:0] out_pixel_addr;
  logic [7:0]            out_pixel_byte;
  logic                  out_frame_done;
  logic                  out_header_error;
  logic                  out_cmd_write;
  logic [LINE_IDX_W-1:0] out_cmd_index;
  logic [7:0]            out_cmd_byte;
  logic                  out_cmd_line_done;
  logic [LINE_IDX_W-1:0] out_cmd_length;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  led_frame_and_command_deframer_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_write   (out_pixel_write),
    .out_pixel_addr    (out_pixel_addr),
    .out_pixel_byte    (out_pixel_byte),
    .out_frame_done    (out_frame_done),
    .out_header_error  (out_header_error),
    .out_cmd_write     (out_cmd_write),
    .out_cmd_index     (out_cmd_index),
    .out_cmd_byte      (out_cmd_byte),
    .out_cmd_line_done (out_cmd_line_done),
    .out_cmd_length    (out_cmd_length),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #2 clk = ~clk;

  // parser shadow
  cfg_t                  cfg_shadow = '{led_count: '0, target_present: 1'b1};
  parse_state_t          ps = ST_IDLE;
  logic [7:0]            hdr_hi = '0;
  logic [7:0]            hdr_lo = '0;
  int                    pay_cnt = 0;
  logic [LED_COUNT_W-1:0] lat_leds = '0;
  logic [LINE_IDX_W-1:0] line_idx = '0;

  logic [7:0] rx_byte_q[$];
  result_t    parsed_q[$];
  int         n_queued = 0;
  int         n_taken = 0;
  int         n_errors = 0;
  bit         in_acc = 1'b0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  bit         hold_start = 1'b0;
  int         hold_left = 0;

  function automatic result_t parse_byte(input logic [7:0] c);
    result_t r;
    int      total;
    r = '0;
    case (ps)
      ST_IDLE: begin
        if (c == CharUpperA) ps = ST_ADA_D;
        else if (c == CharUpperC) ps = ST_CMD_M;
      end
      ST_ADA_D: begin
        if (c == CharLowD) ps = ST_ADA_A;
        else begin ps = ST_IDLE; r.header_error = 1'b1; end
      end
      ST_ADA_A: begin
        if (c == CharLowA) ps = ST_ADA_HI;
        else begin ps = ST_IDLE; r.header_error = 1'b1; end
      end
      ST_ADA_HI: begin
        hdr_hi = c;
        ps = ST_ADA_LO;
      end
      ST_ADA_LO: begin
        hdr_lo = c;
        ps = ST_ADA_CHK;
      end
      ST_ADA_CHK: begin
        if ((hdr_hi ^ hdr_lo ^ ChkSeed) == c) begin
          pay_cnt = 0;
          lat_leds = (cfg_shadow.led_count > MaxLeds) ? MaxLeds : cfg_shadow.led_count;
          ps = ST_ADA_DATA;
        end else begin
          ps = ST_IDLE;
          r.header_error = 1'b1;
        end
      end
      ST_ADA_DATA: begin
        if (!cfg_shadow.target_present) begin
          ps = ST_IDLE;
          r.header_error = 1'b1;
        end else begin
          total = 3 * int'(lat_leds);
          if (pay_cnt < total) begin
            r.pixel_write = 1'b1;
            r.pixel_addr = pay_cnt[PIX_ADDR_W-1:0];
            r.pixel_byte = c;
            pay_cnt++;
          end
          if (pay_cnt >= total) begin
            ps = ST_IDLE;
            r.frame_done = 1'b1;
          end
        end
      end
      ST_CMD_M: begin
        if (c == CharLowM) ps = ST_CMD_D;
        else begin ps = ST_IDLE; r.header_error = 1'b1; end
      end
      ST_CMD_D: begin
        if (c == CharLowD) begin
          ps = ST_CMD_LINE;
          line_idx = '0;
        end else begin
          ps = ST_IDLE;
          r.header_error = 1'b1;
        end
      end
      ST_CMD_LINE: begin
        if (c == CharNewline) begin
          r.cmd_line_done = 1'b1;
          r.cmd_length = line_idx;
          ps = ST_IDLE;
        end else if (line_idx < LineLast) begin
          r.cmd_write = 1'b1;
          r.cmd_index = line_idx;
          r.cmd_byte = c;
          line_idx++;
        end
      end
      default: ps = ST_IDLE;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < 100) $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic compare_result(input result_t got, input result_t want);
    if (got.pixel_write !== want.pixel_write)
      report_mismatch($sformatf("pixel_write %0h want %0h", got.pixel_write, want.pixel_write));
    if (got.pixel_addr !== want.pixel_addr)
      report_mismatch($sformatf("pixel_addr %0h want %0h", got.pixel_addr, want.pixel_addr));
    if (got.pixel_byte !== want.pixel_byte)
      report_mismatch($sformatf("pixel_byte %0h want %0h", got.pixel_byte, want.pixel_byte));
    if (got.frame_done !== want.frame_done)
      report_mismatch($sformatf("frame_done %0h want %0h", got.frame_done, want.frame_done));
    if (got.header_error !== want.header_error)
      report_mismatch($sformatf("header_error %0h want %0h", got.header_error,
                                want.header_error));
    if (got.cmd_write !== want.cmd_write)
      report_mismatch($sformatf("cmd_write %0h want %0h", got.cmd_write, want.cmd_write));
    if (got.cmd_index !== want.cmd_index)
      report_mismatch($sformatf("cmd_index %0h want %0h", got.cmd_index, want.cmd_index));
    if (got.cmd_byte !== want.cmd_byte)
      report_mismatch($sformatf("cmd_byte %0h want %0h", got.cmd_byte, want.cmd_byte));
    if (got.cmd_line_done !== want.cmd_line_done)
      report_mismatch($sformatf("cmd_line_done %0h want %0h", got.cmd_line_done,
                                want.cmd_line_done));
    if (got.cmd_length !== want.cmd_length)
      report_mismatch($sformatf("cmd_length %0h want %0h", got.cmd_length, want.cmd_length));
  endtask

  // request driver
  always @(negedge clk) begin
    if (in_valid && !in_acc) begin
      in_valid <= 1'b1;
    end else begin
      in_acc = 1'b0;
      if (rx_byte_q.size() > 0 && $urandom_range(99, 0) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= rcv_idle_pct);
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left = 600;
      hold_start = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.pixel_write   = out_pixel_write;
        got.pixel_addr    = out_pixel_addr;
        got.pixel_byte    = out_pixel_byte;
        got.frame_done    = out_frame_done;
        got.header_error  = out_header_error;
        got.cmd_write     = out_cmd_write;
        got.cmd_index     = out_cmd_index;
        got.cmd_byte      = out_cmd_byte;
        got.cmd_line_done = out_cmd_line_done;
        got.cmd_length    = out_cmd_length;
        if (parsed_q.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = parsed_q.pop_front();
          compare_result(got, want);
        end
      end
      if (in_valid && in_ready) begin
        parsed_q.push_back(parse_byte(in_rx_byte));
        n_taken++;
        in_acc = 1'b1;
      end
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    logic [APB_DATA_W-1:0] rd_want;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_LED_COUNT) begin
      cfg_shadow.led_count = val[LED_COUNT_W-1:0];
      rd_want = APB_DATA_W'(cfg_shadow.led_count);
    end else begin
      cfg_shadow.target_present = val[0];
      rd_want = APB_DATA_W'(cfg_shadow.target_present);
    end
    @(negedge clk);
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== rd_want)
      report_mismatch($sformatf("register %0d reads %0h want %0h", idx, prdata, rd_want));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_byte_q.push_back(b);
    n_queued++;
  endtask

  task automatic push_frame(input logic [7:0] hi, input logic [7:0] lo, input bit good);
    logic [7:0] chk;
    int         leds;
    int         n;
    chk = hi ^ lo ^ ChkSeed;
    push_byte(CharUpperA);
    push_byte(CharLowD);
    push_byte(CharLowA);
    push_byte(hi);
    push_byte(lo);
    push_byte(good ? chk : ~chk);
    if (good) begin
      leds = (cfg_shadow.led_count > MaxLeds) ? int'(MaxLeds) : int'(cfg_shadow.led_count);
      n = (!cfg_shadow.target_present || leds == 0) ? 1 : 3 * leds;
      repeat (n) push_byte(8'($urandom));
    end
  endtask

  task automatic push_cmd_line(input int len);
    logic [7:0] b;
    push_byte(CharUpperC);
    push_byte(CharLowM);
    push_byte(CharLowD);
    repeat (len) begin
      do b = 8'($urandom); while (b == CharNewline);
      push_byte(b);
    end
    push_byte(CharNewline);
  endtask

  task automatic push_noise();
    logic [7:0] b;
    case ($urandom_range(4, 0))
      0: repeat ($urandom_range(3, 1)) push_byte(8'($urandom));
      1: begin
        push_byte(CharUpperA);
        do b = 8'($urandom); while (b == CharLowD);
        push_byte(b);
      end
      2: begin
        push_byte(CharUpperA);
        push_byte(CharLowD);
        do b = 8'($urandom); while (b == CharLowA);
        push_byte(b);
      end
      3: begin
        push_byte(CharUpperC);
        do b = 8'($urandom); while (b == CharLowM);
        push_byte(b);
      end
      default: begin
        push_byte(CharUpperC);
        push_byte(CharLowM);
        do b = 8'($urandom); while (b == CharLowD);
        push_byte(b);
      end
    endcase
  endtask

  task automatic run_mix(input int n_items);
    int start;
    int pick;
    start = n_queued;
    while (n_queued - start < n_items) begin
      pick = $urandom_range(99, 0);
      if (pick < 55) push_frame(8'($urandom), 8'($urandom), $urandom_range(9, 0) != 0);
      else if (pick < 80) push_cmd_line($urandom_range(24, 0));
      else push_noise();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_taken != n_queued || parsed_q.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // bring the parser back to idle before touching the registers
  task automatic settle_parser();
    logic [7:0] b;
    wait_drained();
    while (ps != ST_IDLE) begin
      case (ps)
        ST_ADA_CHK:  b = ~(hdr_hi ^ hdr_lo ^ ChkSeed);
        ST_CMD_LINE: b = CharNewline;
        default:     b = 8'h00;
      endcase
      @(posedge clk);
      push_byte(b);
      wait_drained();
    end
  endtask

  task automatic set_idling(input int snd, input int rcv);
    @(posedge clk);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  initial begin : timeout
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stim
    int k;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    cfg_write(REG_LED_COUNT, 32'd2);
    cfg_write(REG_TARGET_PRESENT, 32'd1);
    set_idling(32, 74);

    // directed: noise, broken syncs, bad and good headers, a short command
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(CharUpperA);
    push_byte(8'h00);
    push_byte(CharUpperA);
    push_byte(CharLowD);
    push_byte(8'hff);
    push_byte(CharUpperC);
    push_byte(CharLowD);
    push_byte(CharUpperC);
    push_byte(CharLowM);
    push_byte(CharLowA);
    push_frame(8'hff, 8'h00, 1'b0);
    push_frame(8'h00, 8'hff, 1'b1);
    push_cmd_line(2);
    settle_parser();

    // zero leds, then missing target
    cfg_write(REG_LED_COUNT, 32'd0);
    @(posedge clk);
    push_frame(8'h12, 8'h34, 1'b1);
    settle_parser();
    cfg_write(REG_LED_COUNT, 32'd1);
    cfg_write(REG_TARGET_PRESENT, 32'd0);
    @(posedge clk);
    push_frame(8'h56, 8'h78, 1'b1);
    settle_parser();

    for (int sub = 0; sub < 6; sub++) begin
      case (sub / 2)
        0: set_idling(32, 74);
        1: set_idling(74, 32);
        default: set_idling(0, 0);
      endcase
      cfg_write(REG_LED_COUNT, (sub == 1) ? 32'd0 : 32'($urandom_range(6, 1)));
      cfg_write(REG_TARGET_PRESENT, (sub == 3) ? 32'd0 : 32'd1);
      @(posedge clk);
      run_mix(200);
      if (sub == 4) begin
        @(negedge clk);
        hold_start = 1'b1;
      end
      settle_parser();
    end

    // an overlong command line, then one just under the length limit
    set_idling(0, 0);
    cfg_write(REG_TARGET_PRESENT, 32'd1);
    @(posedge clk);
    push_cmd_line(300);
    push_cmd_line(254);

    k = 0;
    while ((n_taken != n_queued || parsed_q.size() != 0) && k < 200000) begin
      @(negedge clk);
      k++;
    end
    repeat (20) @(negedge clk);
    if (n_taken != n_queued || parsed_q.size() != 0)
      report_mismatch($sformatf("%0d results still outstanding", parsed_q.size()));
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
